### hdl/stf_pkg.sv
package stf_pkg;

  localparam int REQ_TYPE_W = 2;
  localparam int REC_W      = 64;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 32;
  localparam int KIND_W     = 2;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_PROBE = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PASS  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_FULL  = 2'd2,
    KIND_RANGE = 2'd3
  } kind_t;

  // read address source for both table memories
  typedef enum logic [1:0] {
    RD_SRCH  = 2'd0,
    RD_POS   = 2'd1,
    RD_RIDX  = 2'd2,
    RD_SHIFT = 2'd3
  } rd_sel_t;

  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_DECODE    = 3'd1,
    S_SEARCH    = 3'd2,
    S_FOUND     = 3'd3,
    S_SHIFT     = 3'd4,
    S_INSERT    = 3'd5,
    S_PROBE_CHK = 3'd6,
    S_READ_OUT  = 3'd7
  } state_t;

  typedef struct packed {
    logic    take;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    srch_step;
    logic    shift_step;
    logic    insert;
    logic    cnt_bump;
    logic    emit;
    kind_t   kind;
  } stf_cmd_t;

  typedef struct packed {
    req_type_t req_type;
    logic      full;
    logic      srch_more;
    logic      pos_valid;
    logic      k_above;
    logic      k_above2;
    logic      read_ok;
    logic      hit;
    logic      count_mode;
    logic      out_free;
  } stf_status_t;

endpackage

### hdl/stf_req_if.sv
interface stf_req_if;
  logic                             valid;
  logic                             ready;
  logic [stf_pkg::REQ_TYPE_W-1:0]   req_type;
  logic [stf_pkg::REC_W-1:0]        record;
  logic [stf_pkg::IDX_W-1:0]        read_index;

  modport source (output valid, req_type, record, read_index, input ready);
  modport sink   (input valid, req_type, record, read_index, output ready);
endinterface

### hdl/stf_res_if.sv
interface stf_res_if;
  logic                         valid;
  logic                         ready;
  logic [stf_pkg::KIND_W-1:0]   result_kind;
  logic [stf_pkg::REC_W-1:0]    out_record;
  logic [stf_pkg::CNT_W-1:0]    match_count;
  logic [stf_pkg::IDX_W-1:0]    entry_index;

  modport source (output valid, result_kind, out_record, match_count, entry_index,
                  input ready);
  modport sink   (input valid, result_kind, out_record, match_count, entry_index,
                  output ready);
endinterface

### hdl/stf_ram.sv
module stf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/stf_ctrl.sv
module stf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  stf_pkg::stf_status_t sts,
  output stf_pkg::stf_cmd_t    cmd
);

  stf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      stf_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = stf_pkg::S_DECODE;
        end
      end
      stf_pkg::S_DECODE: begin
        unique case (sts.req_type)
          stf_pkg::REQ_LOAD, stf_pkg::REQ_PROBE: begin
            if (sts.req_type == stf_pkg::REQ_LOAD && sts.full) begin
              cmd.kind = stf_pkg::KIND_FULL;
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                state_next = stf_pkg::S_IDLE;
              end
            end else begin
              // first probe of the search
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = stf_pkg::RD_SRCH;
              state_next = sts.srch_more ? stf_pkg::S_SEARCH : stf_pkg::S_FOUND;
            end
          end
          stf_pkg::REQ_READ: begin
            if (sts.read_ok) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = stf_pkg::RD_RIDX;
              state_next = stf_pkg::S_READ_OUT;
            end else begin
              cmd.kind = stf_pkg::KIND_RANGE;
              if (sts.out_free) begin
                cmd.emit   = 1'b1;
                state_next = stf_pkg::S_IDLE;
              end
            end
          end
          stf_pkg::REQ_NOP: begin
            state_next = stf_pkg::S_IDLE;
          end
        endcase
      end
      stf_pkg::S_SEARCH: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = stf_pkg::RD_SRCH;
        cmd.srch_step = 1'b1;
        if (!sts.srch_more) begin
          state_next = stf_pkg::S_FOUND;
        end
      end
      stf_pkg::S_FOUND: begin
        if (sts.req_type == stf_pkg::REQ_LOAD) begin
          if (sts.k_above) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = stf_pkg::RD_SHIFT;
            state_next = stf_pkg::S_SHIFT;
          end else begin
            state_next = stf_pkg::S_INSERT;
          end
        end else if (sts.pos_valid) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = stf_pkg::RD_POS;
          state_next = stf_pkg::S_PROBE_CHK;
        end else begin
          state_next = stf_pkg::S_IDLE;
        end
      end
      stf_pkg::S_SHIFT: begin
        // move one entry up per cycle, reading the next one down
        cmd.shift_step = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = stf_pkg::RD_SHIFT;
        if (!sts.k_above2) begin
          state_next = stf_pkg::S_INSERT;
        end
      end
      stf_pkg::S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = stf_pkg::S_IDLE;
      end
      stf_pkg::S_PROBE_CHK: begin
        cmd.kind = stf_pkg::KIND_PASS;
        if (!sts.hit) begin
          state_next = stf_pkg::S_IDLE;
        end else if (sts.count_mode) begin
          cmd.cnt_bump = 1'b1;
          state_next   = stf_pkg::S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stf_pkg::S_IDLE;
        end
      end
      stf_pkg::S_READ_OUT: begin
        cmd.kind = stf_pkg::KIND_COUNT;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stf_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

### hdl/stf_dpath.sv
module stf_dpath #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int RECORD_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  stf_pkg::stf_cmd_t                 cmd,
  output stf_pkg::stf_status_t              sts,
  input  logic [stf_pkg::REQ_TYPE_W-1:0]    req_type,
  input  logic [stf_pkg::REC_W-1:0]         record,
  input  logic [stf_pkg::IDX_W-1:0]         read_index,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [stf_pkg::KIND_W-1:0]        result_kind,
  output logic [stf_pkg::REC_W-1:0]         out_record,
  output logic [stf_pkg::CNT_W-1:0]         match_count,
  output logic [stf_pkg::IDX_W-1:0]         entry_index
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int RW  = 8 * RECORD_BYTES;
  localparam int IXW = (CW > stf_pkg::IDX_W) ? CW : stf_pkg::IDX_W;

  stf_pkg::req_type_t          req_q;
  logic [RW-1:0]               key;
  logic [stf_pkg::IDX_W-1:0]   ridx;
  logic [CW-1:0]               lo, hi, k, total;
  logic [AW-1:0]               mid;
  logic                        count_mode;

  logic [RW-1:0]               tbl_q;
  logic [stf_pkg::CNT_W-1:0]   cnt_q;

  logic [CW-1:0]               mid_ext, lo_n, hi_n, mid_n, k_dec1, k_dec2;
  logic [IXW-1:0]              ridx_ext, total_ext, lo_ext;
  logic                        go_right;
  logic [AW-1:0]               raddr, waddr;
  logic                        tbl_we, cnt_we;
  logic [RW-1:0]               tbl_wdata;
  logic [stf_pkg::CNT_W-1:0]   cnt_wdata, cnt_sat;

  always_comb begin
    mid_ext   = CW'(mid);
    k_dec1    = k - CW'(1);
    k_dec2    = k - CW'(2);
    ridx_ext  = IXW'(ridx);
    total_ext = IXW'(total);
    lo_ext    = IXW'(lo);

    // loads look for the first entry above the key, probes the first not below
    go_right = (req_q == stf_pkg::REQ_LOAD) ? (tbl_q <= key) : (tbl_q < key);
    lo_n = lo;
    hi_n = hi;
    if (cmd.srch_step) begin
      if (go_right) begin
        lo_n = mid_ext + CW'(1);
      end else begin
        hi_n = mid_ext;
      end
    end
    mid_n = lo_n + ((hi_n - lo_n) >> 1);

    unique case (cmd.rd_sel)
      stf_pkg::RD_SRCH:  raddr = mid_n[AW-1:0];
      stf_pkg::RD_POS:   raddr = lo[AW-1:0];
      stf_pkg::RD_RIDX:  raddr = ridx_ext[AW-1:0];
      stf_pkg::RD_SHIFT: raddr = cmd.shift_step ? k_dec2[AW-1:0] : k_dec1[AW-1:0];
    endcase

    cnt_sat = (cnt_q == '1) ? cnt_q : cnt_q + stf_pkg::CNT_W'(1);

    tbl_we    = cmd.shift_step | cmd.insert;
    cnt_we    = cmd.shift_step | cmd.insert | cmd.cnt_bump;
    waddr     = cmd.shift_step ? k[AW-1:0] : lo[AW-1:0];
    tbl_wdata = cmd.shift_step ? tbl_q : key;
    priority if (cmd.shift_step) begin
      cnt_wdata = cnt_q;
    end else if (cmd.cnt_bump) begin
      cnt_wdata = cnt_sat;
    end else begin
      cnt_wdata = '0;
    end

    sts.req_type   = req_q;
    sts.full       = (total >= CW'(TABLE_DEPTH));
    sts.srch_more  = (lo_n < hi_n);
    sts.pos_valid  = (lo < total);
    sts.k_above    = (k > lo);
    sts.k_above2   = (k_dec1 > lo);
    sts.read_ok    = (ridx_ext < total_ext);
    sts.hit        = (tbl_q == key);
    sts.count_mode = count_mode;
    sts.out_free   = !out_valid || out_ready;
  end

  stf_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (tbl_wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (tbl_q)
  );

  stf_ram #(.WIDTH(stf_pkg::CNT_W), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (waddr),
    .wdata (cnt_wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (cnt_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= '0;
      count_mode <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_mode <= cfg_wr_data;
      end
      if (cmd.insert) begin
        total <= total + CW'(1);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      req_q <= stf_pkg::req_type_t'(req_type);
      key   <= record[RW-1:0];
      ridx  <= read_index;
      lo    <= '0;
      hi    <= total;
      k     <= total;
    end
    if (cmd.srch_step) begin
      lo <= lo_n;
      hi <= hi_n;
    end
    if (cmd.rd_en && cmd.rd_sel == stf_pkg::RD_SRCH) begin
      mid <= mid_n[AW-1:0];
    end
    if (cmd.shift_step) begin
      k <= k_dec1;
    end
    if (cmd.emit) begin
      result_kind <= cmd.kind;
      unique case (cmd.kind)
        stf_pkg::KIND_PASS: begin
          out_record  <= stf_pkg::REC_W'(key);
          match_count <= '0;
          entry_index <= lo_ext[stf_pkg::IDX_W-1:0];
        end
        stf_pkg::KIND_COUNT: begin
          out_record  <= stf_pkg::REC_W'(tbl_q);
          match_count <= cnt_q;
          entry_index <= ridx;
        end
        stf_pkg::KIND_FULL: begin
          out_record  <= stf_pkg::REC_W'(key);
          match_count <= '0;
          entry_index <= '0;
        end
        stf_pkg::KIND_RANGE: begin
          out_record  <= '0;
          match_count <= '0;
          entry_index <= ridx;
        end
      endcase
    end
  end

endmodule

### hdl/sorted_table_record_filter_unit.sv
// channel   dir  handshake            payload
// req_ch    in   valid / ready        req_type, record, read_index
// res_ch    out  valid / ready        result_kind, out_record, match_count, entry_index
// cfg       in   cfg_wr_en            cfg_wr_data (count_mode)
//
// one item at a time; ready is high only while the controller is idle
// read: a single table read; probe: a binary search, one search step
// per cycle through the registered read port of the table memory
// load: search, then each entry above the insert point moves up via the one write port
// a finished result sits in the output register while the next item is taken;
// the controller waits only when a new result meets a full output register
// synchronous reset empties the table at once, no clearing pass
module sorted_table_record_filter_unit #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int RECORD_BYTES = 8
) (
  input logic       clk,
  input logic       rst,
  stf_req_if.sink   req_ch,
  stf_res_if.source res_ch,
  input logic       cfg_wr_en,
  input logic       cfg_wr_data
);

  stf_pkg::stf_cmd_t    cmd;
  stf_pkg::stf_status_t sts;
  logic                 req_ready;

  assign req_ch.ready = req_ready;

  stf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stf_dpath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .RECORD_BYTES (RECORD_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_ch.req_type),
    .record      (req_ch.record),
    .read_index  (req_ch.read_index),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (res_ch.ready),
    .out_valid   (res_ch.valid),
    .result_kind (res_ch.result_kind),
    .out_record  (res_ch.out_record),
    .match_count (res_ch.match_count),
    .entry_index (res_ch.entry_index)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over one not yet transferred");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !sts.full)
    else $error("insert into a full table");

  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_step |-> sts.k_above)
    else $error("entry shift below the insert point");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.shift_step, cmd.insert, cmd.cnt_bump}))
    else $error("conflicting table writes");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> !req_ch.ready)
    else $error("ready right after a request transfer");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int TABLE_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PCT    = 32;
  localparam bit FILTER_MODE = 1'b0;
  localparam bit COUNT_MODE  = 1'b1;
  localparam logic [stf_pkg::REC_W-1:0] ALL_ONES  = {stf_pkg::REC_W{1'b1}};
  localparam logic [stf_pkg::REC_W-1:0] FILL_BASE = 64'hFFFF_FF00_0000_0000;
  localparam logic [stf_pkg::CNT_W-1:0] CNT_TOP   = {stf_pkg::CNT_W{1'b1}};

  typedef struct packed {
    stf_pkg::kind_t            kind;
    logic [stf_pkg::REC_W-1:0] rec;
    logic [stf_pkg::CNT_W-1:0] cnt;
    logic [stf_pkg::IDX_W-1:0] idx;
  } result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  stf_req_if req_ch ();
  stf_res_if res_ch ();

  sorted_table_record_filter_unit #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .RECORD_BYTES(8)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .req_ch     (req_ch),
    .res_ch     (res_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // shadow copy of the sorted table
  logic [stf_pkg::REC_W-1:0] good_recs [TABLE_DEPTH];
  logic [stf_pkg::CNT_W-1:0] hit_cnts  [TABLE_DEPTH];
  int unsigned      n_entries;
  bit               count_on;

  result_t                   expected_q [$];
  logic [stf_pkg::REC_W-1:0] loaded_recs [$];
  int                        err_count = 0;
  int unsigned               cycle_cnt = 0;
  bit                        idle_on;

  task automatic report_err(string what, logic [stf_pkg::REC_W-1:0] got,
                            logic [stf_pkg::REC_W-1:0] want);
    $display("mismatch @%0d: %s got %h want %h", cycle_cnt, what, got, want);
    err_count++;
  endtask

  // first position whose entry is >= key, or > key when past_equal is set
  function automatic int unsigned sorted_bound(logic [stf_pkg::REC_W-1:0] key,
                                               bit past_equal);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = n_entries;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (past_equal ? (good_recs[mid] <= key) : (good_recs[mid] < key)) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void apply_request(stf_pkg::req_type_t kind,
                                        logic [stf_pkg::REC_W-1:0] rec,
                                        logic [stf_pkg::IDX_W-1:0] ridx);
    int unsigned pos;
    result_t     res;
    res = '0;
    case (kind)
      stf_pkg::REQ_LOAD: begin
        if (n_entries >= TABLE_DEPTH) begin
          res.kind = stf_pkg::KIND_FULL;
          res.rec  = rec;
          expected_q.push_back(res);
        end else begin
          pos = sorted_bound(rec, 1'b1);
          for (int unsigned k = n_entries; k > pos; k--) begin
            good_recs[k] = good_recs[k-1];
            hit_cnts[k]  = hit_cnts[k-1];
          end
          good_recs[pos] = rec;
          hit_cnts[pos]  = '0;
          n_entries++;
          loaded_recs.push_back(rec);
        end
      end
      stf_pkg::REQ_PROBE: begin
        pos = sorted_bound(rec, 1'b0);
        if (pos < n_entries && good_recs[pos] == rec) begin
          if (count_on) begin
            if (hit_cnts[pos] != CNT_TOP) hit_cnts[pos]++;
          end else begin
            res.kind = stf_pkg::KIND_PASS;
            res.rec  = rec;
            res.idx  = pos[stf_pkg::IDX_W-1:0];
            expected_q.push_back(res);
          end
        end
      end
      stf_pkg::REQ_READ: begin
        res.idx = ridx;
        if (ridx < n_entries) begin
          res.kind = stf_pkg::KIND_COUNT;
          res.rec  = good_recs[ridx];
          res.cnt  = hit_cnts[ridx];
        end else begin
          res.kind = stf_pkg::KIND_RANGE;
        end
        expected_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(stf_pkg::req_type_t kind, logic [stf_pkg::REC_W-1:0] rec,
                           logic [stf_pkg::IDX_W-1:0] ridx);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.record     <= rec;
    req_ch.read_index <= ridx;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    apply_request(kind, rec, ridx);
  endtask

  // hold off until every result is in and a worst-case load has finished
  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (n_entries + 40) @(posedge clk);
  endtask

  task automatic set_mode(bit mode);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    count_on = mode;
  endtask

  // mostly records already in the table or their neighbors, so hits and ties are common
  function automatic logic [stf_pkg::REC_W-1:0] pick_record();
    logic [stf_pkg::REC_W-1:0] r;
    int unsigned               sel;
    sel = $urandom_range(99);
    r   = {$urandom, $urandom};
    if (loaded_recs.size() > 0 && sel < 55) begin
      r = loaded_recs[$urandom_range(loaded_recs.size() - 1)];
      if (sel >= 47) r = r + 64'd1;
      else if (sel >= 40) r = r - 64'd1;
    end else if (sel < 75) begin
      r = {60'd0, r[3:0]};
    end
    return r;
  endfunction

  task automatic random_item(int unsigned load_pct);
    int unsigned               sel;
    logic [stf_pkg::IDX_W-1:0] ridx;
    sel  = $urandom_range(99);
    ridx = stf_pkg::IDX_W'($urandom_range(TABLE_DEPTH - 1));
    if (n_entries > 0 && $urandom_range(99) < 70)
      ridx = stf_pkg::IDX_W'($urandom_range(n_entries - 1));
    if (sel < load_pct) send_item(stf_pkg::REQ_LOAD, pick_record(), ridx);
    else if (sel < load_pct + 45) send_item(stf_pkg::REQ_PROBE, pick_record(), ridx);
    else if (sel < 96) send_item(stf_pkg::REQ_READ, pick_record(), ridx);
    else send_item(stf_pkg::REQ_NOP, pick_record(), ridx);
  endtask

  task automatic test_directed_filter();
    set_mode(FILTER_MODE);
    send_item(stf_pkg::REQ_READ, '0, '0);
    send_item(stf_pkg::REQ_READ, ALL_ONES, 10'h3FF);
    send_item(stf_pkg::REQ_PROBE, '0, '0);
    send_item(stf_pkg::REQ_LOAD, ALL_ONES, '0);
    send_item(stf_pkg::REQ_LOAD, '0, '0);
    send_item(stf_pkg::REQ_LOAD, '0, 10'h3FF);
    send_item(stf_pkg::REQ_LOAD, 64'h8000_0000_0000_0000, '0);
    send_item(stf_pkg::REQ_LOAD, 64'h0123_4567_89AB_CDEF, '0);
    send_item(stf_pkg::REQ_NOP, 64'hDEAD_BEEF_0BAD_F00D, 10'h155);
    send_item(stf_pkg::REQ_PROBE, '0, '0);
    send_item(stf_pkg::REQ_PROBE, ALL_ONES, '0);
    send_item(stf_pkg::REQ_PROBE, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    for (int i = 0; i <= 5; i++) send_item(stf_pkg::REQ_READ, '0, stf_pkg::IDX_W'(i));
  endtask

  task automatic test_directed_count();
    set_mode(COUNT_MODE);
    send_item(stf_pkg::REQ_PROBE, '0, '0);
    send_item(stf_pkg::REQ_PROBE, '0, '0);
    send_item(stf_pkg::REQ_PROBE, ALL_ONES, '0);
    send_item(stf_pkg::REQ_PROBE, 64'd1, '0);
    send_item(stf_pkg::REQ_READ, '0, 10'd0);
    send_item(stf_pkg::REQ_READ, '0, 10'd1);
    send_item(stf_pkg::REQ_READ, '0, 10'd4);
    // a third copy lands after the equal ones and starts from zero
    send_item(stf_pkg::REQ_LOAD, '0, '0);
    for (int i = 0; i <= 3; i++) send_item(stf_pkg::REQ_READ, '0, stf_pkg::IDX_W'(i));
  endtask

  task automatic test_random_mix();
    for (int chunk = 0; chunk < 4; chunk++) begin
      set_mode(chunk[0] ? COUNT_MODE : FILTER_MODE);
      idle_on = (chunk != 2);
      repeat (90) random_item(30);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_table_full();
    set_mode(FILTER_MODE);
    while (n_entries < TABLE_DEPTH) begin
      send_item(stf_pkg::REQ_LOAD, FILL_BASE + n_entries, '0);
      if (n_entries % 32 == 0)
        send_item(stf_pkg::REQ_READ, '0, stf_pkg::IDX_W'($urandom_range(n_entries - 1)));
    end
    send_item(stf_pkg::REQ_LOAD, ALL_ONES, '0);
    send_item(stf_pkg::REQ_LOAD, '0, '0);
    repeat (4) send_item(stf_pkg::REQ_LOAD, pick_record(), '0);
    send_item(stf_pkg::REQ_READ, '0, 10'h3FF);
    send_item(stf_pkg::REQ_READ, '0, 10'h000);
    send_item(stf_pkg::REQ_PROBE, ALL_ONES, '0);
  endtask

  task automatic test_full_random();
    set_mode(COUNT_MODE);
    repeat (60) random_item(10);
    set_mode(FILTER_MODE);
    repeat (60) random_item(10);
  endtask

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_err("result with nothing expected", res_ch.out_record, '0);
      end else begin
        want = expected_q.pop_front();
        if (res_ch.result_kind !== want.kind)
          report_err("result_kind", stf_pkg::REC_W'(res_ch.result_kind),
                     stf_pkg::REC_W'(want.kind));
        if (res_ch.out_record !== want.rec)
          report_err("out_record", res_ch.out_record, want.rec);
        if (res_ch.match_count !== want.cnt)
          report_err("match_count", stf_pkg::REC_W'(res_ch.match_count),
                     stf_pkg::REC_W'(want.cnt));
        if (res_ch.entry_index !== want.idx)
          report_err("entry_index", stf_pkg::REC_W'(res_ch.entry_index),
                     stf_pkg::REC_W'(want.idx));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = stf_pkg::REQ_NOP;
    req_ch.record     = '0;
    req_ch.read_index = '0;
    n_entries         = 0;
    count_on          = FILTER_MODE;
    idle_on           = 1'b1;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      good_recs[i] = '0;
      hit_cnts[i]  = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_filter();
    test_directed_count();
    test_random_mix();
    test_table_full();
    test_full_random();

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
